// ===== hdl/hbd_pkg.sv =====
// Shared types, constants and helpers for the chunked body deframer.
`default_nettype none

package hbd_pkg;

   localparam int MAX_LINE_DEF    = 33;
   localparam int COUNT_WIDTH_DEF = 32;

   localparam int BYTE_W     = 8;
   localparam int BODY_LEN_W = 32;
   localparam int SIZE_W     = 32;
   localparam int LINE_LEN_W = 6;
   localparam int DIGIT_W    = 4;
   localparam int ERR_W      = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DIGIT_W-1:0] MAX_DIGITS = 4'd8;

   localparam logic [BYTE_W-1:0] ASCII_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] ASCII_CR = 8'h0D;

   // sticky error codes
   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FRAME = 2'd1;
   localparam logic [ERR_W-1:0] ERR_LONG  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_AFTER = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNKED_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_KNOWN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_LENGTH  = 2'd2;

   typedef struct packed {
      logic                  chunked_mode;
      logic                  length_known;
      logic [BODY_LEN_W-1:0] body_length;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              data_valid;
      logic              body_end;
      logic [ERR_W-1:0]  error_code;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_type;

   function automatic hex_type hex_decode(input logic [BYTE_W-1:0] b);
      hex_type h;
      h.valid  = 1'b0;
      h.nibble = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.valid  = 1'b1;
         h.nibble = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.valid  = 1'b1;
         h.nibble = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.valid  = 1'b1;
         h.nibble = 4'(b - 8'h37);
      end
      return h;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hbd_core.sv =====
// Framing state and per-byte decode step of the chunked body deframer.
`default_nettype none

module hbd_core
   import hbd_pkg::*;
#(
   parameter int MAX_LINE    = MAX_LINE_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [BYTE_W-1:0] step_byte,
   input  wire cfg_type           cfg,
   output result_type             result
);

   localparam int WIDE_W = (COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [LINE_LEN_W-1:0] LINE_SAT = {LINE_LEN_W{1'b1}};
   localparam logic [LINE_LEN_W-1:0] LINE_LIMIT = LINE_LEN_W'(MAX_LINE);

   localparam logic [2:0] PH_SIZE    = 3'd0;
   localparam logic [2:0] PH_DATA    = 3'd1;
   localparam logic [2:0] PH_DATA_CR = 3'd2;
   localparam logic [2:0] PH_DATA_LF = 3'd3;
   localparam logic [2:0] PH_LAST_CR = 3'd4;
   localparam logic [2:0] PH_LAST_LF = 3'd5;
   localparam logic [2:0] PH_END     = 3'd6;

   logic [2:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] remaining_ff, remaining_in;
   logic [SIZE_W-1:0]      size_accum_ff, size_accum_in;
   logic [LINE_LEN_W-1:0]  line_len_ff, line_len_in;
   logic                   digits_done_ff, digits_done_in;
   logic [DIGIT_W-1:0]     digit_cnt_ff, digit_cnt_in;
   logic [ERR_W-1:0]       sticky_ff, sticky_in;
   logic                   prev_cr_ff, prev_cr_in;

   hex_type                hex;
   logic                   pass;
   logic                   done;
   logic                   digit_overflow;
   logic                   too_big;
   logic [COUNT_WIDTH-1:0] rem_dec;

   always_comb begin
      phase_in       = phase_ff;
      remaining_in   = remaining_ff;
      size_accum_in  = size_accum_ff;
      line_len_in    = line_len_ff;
      digits_done_in = digits_done_ff;
      digit_cnt_in   = digit_cnt_ff;
      sticky_in      = sticky_ff;
      prev_cr_in     = prev_cr_ff;
      pass           = 1'b0;
      done           = 1'b0;
      digit_overflow = 1'b0;
      hex            = hex_decode(step_byte);
      too_big        = WIDE_W'(size_accum_ff) > WIDE_W'(CNT_MAX);
      rem_dec        = (remaining_ff != '0) ? remaining_ff - COUNT_WIDTH'(1) : remaining_ff;

      if (sticky_ff != ERR_NONE) begin
         // dead until reset
      end else if (!cfg.chunked_mode) begin
         if (phase_ff == PH_END) begin
            sticky_in = ERR_AFTER;
         end else if (cfg.length_known &&
                      WIDE_W'(remaining_ff) >= WIDE_W'(cfg.body_length)) begin
            sticky_in = ERR_AFTER;
            phase_in  = PH_END;
         end else begin
            pass = 1'b1;
            if (remaining_ff != CNT_MAX) begin
               remaining_in = remaining_ff + COUNT_WIDTH'(1);
            end
            if (cfg.length_known && WIDE_W'(remaining_in) == WIDE_W'(cfg.body_length)) begin
               done     = 1'b1;
               phase_in = PH_END;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_SIZE: begin
               if (line_len_ff != LINE_SAT) begin
                  line_len_in = line_len_ff + LINE_LEN_W'(1);
               end
               if (step_byte == ASCII_LF) begin
                  if (!prev_cr_ff || digit_cnt_ff == '0 || too_big) begin
                     sticky_in = ERR_FRAME;
                  end else if (size_accum_ff == '0) begin
                     phase_in = PH_LAST_CR;
                  end else begin
                     remaining_in = COUNT_WIDTH'(size_accum_ff);
                     phase_in     = PH_DATA;
                  end
                  size_accum_in  = '0;
                  line_len_in    = '0;
                  digits_done_in = 1'b0;
                  digit_cnt_in   = '0;
                  prev_cr_in     = 1'b0;
               end else begin
                  if (!digits_done_ff) begin
                     if (hex.valid) begin
                        if (digit_cnt_ff >= MAX_DIGITS) begin
                           sticky_in      = ERR_FRAME;
                           digit_overflow = 1'b1;
                        end else begin
                           size_accum_in = {size_accum_ff[SIZE_W-5:0], hex.nibble};
                           digit_cnt_in  = digit_cnt_ff + DIGIT_W'(1);
                        end
                     end else begin
                        // extension or CR: stop reading digits
                        digits_done_in = 1'b1;
                     end
                  end
                  if (!digit_overflow) begin
                     prev_cr_in = (step_byte == ASCII_CR);
                     if (line_len_in >= LINE_LIMIT) begin
                        sticky_in = ERR_LONG;
                     end
                  end
               end
            end
            PH_DATA: begin
               pass         = 1'b1;
               remaining_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (step_byte == ASCII_CR) phase_in = PH_DATA_LF;
               else sticky_in = ERR_FRAME;
            end
            PH_DATA_LF: begin
               if (step_byte == ASCII_LF) begin
                  phase_in       = PH_SIZE;
                  size_accum_in  = '0;
                  line_len_in    = '0;
                  digits_done_in = 1'b0;
                  digit_cnt_in   = '0;
                  prev_cr_in     = 1'b0;
               end else begin
                  sticky_in = ERR_FRAME;
               end
            end
            PH_LAST_CR: begin
               if (step_byte == ASCII_CR) phase_in = PH_LAST_LF;
               else sticky_in = ERR_FRAME;
            end
            PH_LAST_LF: begin
               if (step_byte == ASCII_LF) begin
                  phase_in = PH_END;
                  done     = 1'b1;
               end else begin
                  sticky_in = ERR_FRAME;
               end
            end
            default: begin
               sticky_in = ERR_AFTER;
            end
         endcase
      end

      result.data_byte  = pass ? step_byte : '0;
      result.data_valid = pass;
      result.body_end   = done;
      result.error_code = sticky_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIZE;
         remaining_ff   <= '0;
         size_accum_ff  <= '0;
         line_len_ff    <= '0;
         digits_done_ff <= 1'b0;
         digit_cnt_ff   <= '0;
         sticky_ff      <= ERR_NONE;
         prev_cr_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         remaining_ff   <= remaining_in;
         size_accum_ff  <= size_accum_in;
         line_len_ff    <= line_len_in;
         digits_done_ff <= digits_done_in;
         digit_cnt_ff   <= digit_cnt_in;
         sticky_ff      <= sticky_in;
         prev_cr_ff     <= prev_cr_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/http_body_chunked_deframer.sv =====
// Top level of the HTTP body deframer: byte register, decode core, result register.
`default_nettype none

// Deframes an HTTP response body one byte at a time, either as a plain
// (optionally length-bounded) body or as chunked framing, and returns one
// result per byte: the payload byte with its valid flag, an end-of-body flag
// and a sticky error code that holds until reset. Sustained rate is one byte
// per clock while rsp_stall stays low; a byte's result is registered in the
// byte register and then the result register. The rate is set by the framing
// state update, which is combinational between those registers. Program the
// csr_ registers (csr_ready is always high) only while no byte is in flight.
module http_body_chunked_deframer
   import hbd_pkg::*;
#(
   parameter int MAX_LINE    = MAX_LINE_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_in_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [BYTE_W-1:0]          rsp_data_byte,
   output logic                       rsp_data_valid,
   output logic                       rsp_body_end,
   output logic [ERR_W-1:0]           rsp_error_code,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [BODY_LEN_W-1:0] csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              out_valid_ff, out_valid_in;
   result_type        res_ff, res_in;
   result_type        core_res;
   logic              out_free;
   logic              advance;
   logic              req_take;
   logic              csr_take;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_take) begin
         unique case (csr_index)
            CSR_CHUNKED_MODE: cfg_in.chunked_mode = csr_wdata[0];
            CSR_LENGTH_KNOWN: cfg_in.length_known = csr_wdata[0];
            CSR_BODY_LENGTH:  cfg_in.body_length  = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // the result register frees when empty or when its transfer completes
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      res_in       = res_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         res_in       = core_res;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   hbd_core #(
      .MAX_LINE    (MAX_LINE),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .result    (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      res_ff     <= res_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_data_byte  = res_ff.data_byte;
   assign rsp_data_valid = res_ff.data_valid;
   assign rsp_body_end   = res_ff.body_end;
   assign rsp_error_code = res_ff.error_code;

   // payload only passes while no error is latched
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> rsp_error_code == ERR_NONE)
      else $error("payload byte carries an error code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_body_end |-> rsp_error_code == ERR_NONE)
      else $error("body end reported with an error latched");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_valid |-> rsp_data_byte == '0)
      else $error("framing byte leaked into data_byte");

   // a byte in the input register must move out whenever the result slot frees
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_valid |=> rsp_valid)
      else $error("result register failed to load");

endmodule

`default_nettype wire

// ===== sim/http_body_chunked_deframer_test.sv =====
// Self-checking testbench for the HTTP body deframer: predicted results, random framing, stalls.
module http_body_chunked_deframer_test;
   import hbd_pkg::*;

   localparam int QUIET_LIMIT = 3000;

   typedef enum logic [3:0] {
      PH_SIZE_LINE, PH_CHUNK_DATA, PH_DATA_CR, PH_DATA_LF, PH_LAST_CR, PH_LAST_LF, PH_DONE
   } deframe_phase_type;

   typedef struct {
      deframe_phase_type          phase;
      logic [COUNT_WIDTH_DEF-1:0] remaining;
      logic [SIZE_W-1:0]          size_accum;
      logic [LINE_LEN_W-1:0]      line_len;
      logic                       digits_done;
      logic [DIGIT_W-1:0]         digit_count;
      logic [ERR_W-1:0]           err;
      logic                       prev_cr;
   } deframe_state_type;

   typedef enum int {SPLIT_NONE, SPLIT_LINE, SPLIT_DATA} split_type;

   typedef enum int {
      END_LENGTH_DONE, END_ZERO_LENGTH, END_CHUNKED_DONE, END_NO_DIGITS, END_NINTH_DIGIT,
      END_BARE_LF, END_LONG_LINE, END_DATA_NO_CR, END_DATA_NO_LF, END_LAST_NO_CR, END_SATURATE
   } ending_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic [BYTE_W-1:0]     req_in_byte = '0;
   logic                  rsp_stall   = 1'b0;
   logic                  csr_valid   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [BODY_LEN_W-1:0] csr_wdata   = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [BYTE_W-1:0]     rsp_data_byte;
   logic                  rsp_data_valid;
   logic                  rsp_body_end;
   logic [ERR_W-1:0]      rsp_error_code;
   logic                  csr_ready;

   cfg_type           cfg = '0;
   deframe_state_type plan_state;
   deframe_state_type live_state;
   logic [BYTE_W-1:0] pending_bytes[$];
   result_type        expected_results[$];

   logic        req_took = 1'b0;
   int unsigned sent_count = 0;
   int unsigned send_pct, recv_pct;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned payload_seen = 0;
   int unsigned body_items = 0;
   int unsigned chunk_count = 0;
   int unsigned csr_writes = 0;

   http_body_chunked_deframer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_data_valid (rsp_data_valid),
      .rsp_body_end   (rsp_body_end),
      .rsp_error_code (rsp_error_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic deframe_state_type fresh_line(input deframe_state_type s);
      s.size_accum  = '0;
      s.line_len    = '0;
      s.digits_done = 1'b0;
      s.digit_count = '0;
      s.prev_cr     = 1'b0;
      return s;
   endfunction

   // Advance the deframer state by one byte and produce its result.
   task automatic deframe_step(inout deframe_state_type s, input logic [BYTE_W-1:0] b,
                               output result_type r);
      logic       is_hex;
      logic [3:0] nib;
      logic       is_payload;
      logic       done;
      is_payload = 1'b0;
      done       = 1'b0;
      is_hex     = 1'b1;
      nib        = 4'd0;
      if (b >= "0" && b <= "9") nib = 4'(b - "0");
      else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
      else is_hex = 1'b0;

      if (s.err != ERR_NONE) begin
         // dead until reset
      end else if (!cfg.chunked_mode) begin
         if (s.phase == PH_DONE) begin
            s.err = ERR_AFTER;
         end else if (cfg.length_known && s.remaining >= cfg.body_length) begin
            s.err   = ERR_AFTER;
            s.phase = PH_DONE;
         end else begin
            is_payload = 1'b1;
            if (s.remaining != '1) s.remaining++;
            if (cfg.length_known && s.remaining == cfg.body_length) begin
               done    = 1'b1;
               s.phase = PH_DONE;
            end
         end
      end else begin
         case (s.phase)
            PH_SIZE_LINE: begin
               if (s.line_len != '1) s.line_len++;
               if (b == ASCII_LF) begin
                  // size_accum always fits a 32-bit counter, so no overflow case here
                  if (!s.prev_cr || s.digit_count == 0) begin
                     s.err = ERR_FRAME;
                  end else if (s.size_accum == 0) begin
                     s.phase = PH_LAST_CR;
                  end else begin
                     s.remaining = s.size_accum;
                     s.phase     = PH_CHUNK_DATA;
                  end
                  s = fresh_line(s);
               end else if (!s.digits_done && is_hex && s.digit_count >= MAX_DIGITS) begin
                  s.err = ERR_FRAME;
               end else begin
                  if (!s.digits_done) begin
                     if (is_hex) begin
                        s.size_accum = {s.size_accum[SIZE_W-5:0], nib};
                        s.digit_count++;
                     end else begin
                        s.digits_done = 1'b1;
                     end
                  end
                  s.prev_cr = (b == ASCII_CR);
                  if (s.line_len >= MAX_LINE_DEF) s.err = ERR_LONG;
               end
            end
            PH_CHUNK_DATA: begin
               is_payload = 1'b1;
               if (s.remaining != 0) s.remaining--;
               if (s.remaining == 0) s.phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
               if (b == ASCII_CR) s.phase = PH_DATA_LF;
               else s.err = ERR_FRAME;
            end
            PH_DATA_LF: begin
               if (b == ASCII_LF) begin
                  s.phase = PH_SIZE_LINE;
                  s       = fresh_line(s);
               end else begin
                  s.err = ERR_FRAME;
               end
            end
            PH_LAST_CR: begin
               if (b == ASCII_CR) s.phase = PH_LAST_LF;
               else s.err = ERR_FRAME;
            end
            PH_LAST_LF: begin
               if (b == ASCII_LF) begin
                  s.phase = PH_DONE;
                  done    = 1'b1;
               end else begin
                  s.err = ERR_FRAME;
               end
            end
            default: s.err = ERR_AFTER;
         endcase
      end

      r.data_byte  = is_payload ? b : '0;
      r.data_valid = is_payload;
      r.body_end   = done;
      r.error_code = s.err;
   endtask

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
   endtask

   // Queue one byte for the driver and track where the stream will stand.
   task automatic push_byte(input logic [BYTE_W-1:0] b);
      result_type ignored;
      if (plan_state.err == ERR_NONE) body_items++;
      deframe_step(plan_state, b, ignored);
      pending_bytes.push_back(b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_crlf();
      push_byte(ASCII_CR);
      push_byte(ASCII_LF);
   endtask

   task automatic wait_idle();
      // sample after the driver's updates for this edge have settled
      do begin
         @(negedge clock);
         #1;
      end while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0);
      // let the last byte clear the pipeline
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [BODY_LEN_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_CHUNKED_MODE: cfg.chunked_mode = value[0];
         CSR_LENGTH_KNOWN: cfg.length_known = value[0];
         CSR_BODY_LENGTH:  cfg.body_length  = value;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop into length mode for n bytes, then return to chunked framing.
   task automatic length_stretch(input int unsigned n);
      logic                  bounded;
      logic [BODY_LEN_W-1:0] limit;
      bounded = 1'($urandom_range(1));
      if (bounded) begin
         if ($urandom_range(3) == 0) limit = '1;
         else limit = BODY_LEN_W'(plan_state.remaining + n + $urandom_range(1, 1000));
      end else begin
         case ($urandom_range(2))
            0:       limit = '0;
            1:       limit = '1;
            default: limit = $urandom;
         endcase
      end
      write_csr(CSR_CHUNKED_MODE, BODY_LEN_W'(0));
      write_csr(CSR_LENGTH_KNOWN, BODY_LEN_W'(bounded));
      write_csr(CSR_BODY_LENGTH, limit);
      repeat (n) push_byte(8'($urandom));
      write_csr(CSR_CHUNKED_MODE, BODY_LEN_W'(1));
   endtask

   task automatic send_chunk(input int unsigned size, input split_type split);
      string             digits;
      logic [BYTE_W-1:0] line_q[$];
      logic [BYTE_W-1:0] b;
      int unsigned       pad, ext_len, cut;
      chunk_count++;
      digits = $sformatf("%0h", size);
      if ($urandom_range(1)) digits = digits.toupper();
      pad = ($urandom_range(3) == 0) ? $urandom_range(8 - digits.len()) : 0;
      repeat (pad) line_q.push_back("0");
      for (int i = 0; i < digits.len(); i++) line_q.push_back(digits[i]);
      if ($urandom_range(2) == 0) begin
         // extension keeps the line at least one byte short of the limit
         ext_len = $urandom_range(1, 31 - line_q.size());
         line_q.push_back(";");
         repeat (ext_len - 1) begin
            b = 8'($urandom);
            if (b == ASCII_LF) b = "=";
            line_q.push_back(b);
         end
      end
      cut = (split == SPLIT_LINE) ? $urandom_range(line_q.size()) : line_q.size();
      for (int i = 0; i < cut; i++) push_byte(line_q[i]);
      if (split == SPLIT_LINE) length_stretch($urandom_range(1, 12));
      for (int i = cut; i < line_q.size(); i++) push_byte(line_q[i]);
      push_crlf();
      if (split == SPLIT_DATA && size > 1) begin
         repeat ($urandom_range(1, size - 1)) push_byte(8'($urandom));
         length_stretch($urandom_range(1, 12));
      end
      while (plan_state.phase == PH_CHUNK_DATA) push_byte(8'($urandom));
      push_crlf();
   endtask

   // Driver: present the next byte once the current one has been transferred.
   always @(negedge clock) begin
      if (sent_count < 230) begin
         send_pct = 18;
         recv_pct = 87;
      end else if (sent_count < 460) begin
         send_pct = 87;
         recv_pct = 18;
      end else begin
         send_pct = 0;
         recv_pct = 0;
      end
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < recv_pct);
         if (!req_valid || req_took) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_pct) begin
               req_in_byte <= pending_bytes.pop_front();
               req_valid   <= 1'b1;
               sent_count++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on each byte transfer, check each result transfer.
   always @(posedge clock) begin
      result_type want, got;
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_valid && !req_stall;
         if (req_took) begin
            deframe_step(live_state, req_in_byte, want);
            expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.data_byte  = rsp_data_byte;
            got.data_valid = rsp_data_valid;
            got.body_end   = rsp_body_end;
            got.error_code = rsp_error_code;
            if (got.data_valid) payload_seen++;
            if (expected_results.size() == 0) begin
               flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = expected_results.pop_front();
               if (got.data_byte !== want.data_byte)
                  flag_mismatch($sformatf("result %0d data_byte %0h, expected %0h",
                                          results_seen, got.data_byte, want.data_byte));
               if (got.data_valid !== want.data_valid)
                  flag_mismatch($sformatf("result %0d data_valid %0b, expected %0b",
                                          results_seen, got.data_valid, want.data_valid));
               if (got.body_end !== want.body_end)
                  flag_mismatch($sformatf("result %0d body_end %0b, expected %0b",
                                          results_seen, got.body_end, want.body_end));
               if (got.error_code !== want.error_code)
                  flag_mismatch($sformatf("result %0d error_code %0d, expected %0d",
                                          results_seen, got.error_code, want.error_code));
            end
            results_seen++;
         end
      end
   end

   // Watchdog: end the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      ending_type  ending;
      int unsigned stop_at, pick, size;
      plan_state = '{phase: PH_SIZE_LINE, default: '0};
      live_state = '{phase: PH_SIZE_LINE, default: '0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // length mode, unbounded: framing bytes pass as payload
      write_csr(CSR_BODY_LENGTH, '0);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(ASCII_LF);
      push_byte(ASCII_CR);
      // chunked: eight-digit size line
      write_csr(CSR_CHUNKED_MODE, BODY_LEN_W'(1));
      push_text("00000001");
      push_crlf();
      push_byte(8'h80);
      push_crlf();
      // switch to bounded length mode in the middle of chunk data and back
      push_text("3");
      push_crlf();
      push_byte(8'h55);
      write_csr(CSR_CHUNKED_MODE, BODY_LEN_W'(0));
      write_csr(CSR_LENGTH_KNOWN, BODY_LEN_W'(1));
      write_csr(CSR_BODY_LENGTH, '1);
      push_byte(8'hAA);
      push_byte(8'h7F);
      write_csr(CSR_CHUNKED_MODE, BODY_LEN_W'(1));
      while (plan_state.phase == PH_CHUNK_DATA) push_byte(8'($urandom));
      push_crlf();

      stop_at = body_items + 580;
      while (body_items < stop_at) begin
         pick = $urandom_range(99);
         size = ($urandom_range(6) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         if (pick < 70) send_chunk(size, SPLIT_NONE);
         else if (pick < 80) length_stretch($urandom_range(1, 20));
         else if (pick < 90) send_chunk(size, SPLIT_LINE);
         else send_chunk(size + 1, SPLIT_DATA);
      end

      // close the stream one way or another; errors are sticky, so this comes last
      ending = ending_type'($urandom_range(END_SATURATE));
      case (ending)
         END_LENGTH_DONE: begin
            size = $urandom_range(1, 8);
            write_csr(CSR_CHUNKED_MODE, BODY_LEN_W'(0));
            write_csr(CSR_LENGTH_KNOWN, BODY_LEN_W'(1));
            write_csr(CSR_BODY_LENGTH, BODY_LEN_W'(plan_state.remaining + size));
            repeat (size) push_byte(8'($urandom));
         end
         END_ZERO_LENGTH: begin
            write_csr(CSR_CHUNKED_MODE, BODY_LEN_W'(0));
            write_csr(CSR_LENGTH_KNOWN, BODY_LEN_W'(1));
            write_csr(CSR_BODY_LENGTH, '0);
         end
         END_CHUNKED_DONE: begin
            push_text("000;last");
            push_crlf();
            push_crlf();
         end
         END_NO_DIGITS: begin
            push_text(";x");
            push_crlf();
         end
         END_NINTH_DIGIT: push_text("000000001");
         END_BARE_LF: begin
            push_text("5");
            push_byte(ASCII_LF);
         end
         END_LONG_LINE: begin
            push_text("1;");
            repeat (40) push_text("x");
         end
         END_DATA_NO_CR: begin
            push_text("1");
            push_crlf();
            push_byte(8'($urandom));
            push_text("Z");
         end
         END_DATA_NO_LF: begin
            push_text("1");
            push_crlf();
            push_byte(8'($urandom));
            push_byte(ASCII_CR);
            push_text("Z");
         end
         END_LAST_NO_CR: begin
            push_text("0");
            push_crlf();
            push_text("Z");
         end
         default: begin
            // largest chunk size, then count up in length mode until the counter saturates
            push_text("ffffffff");
            push_crlf();
            repeat (3) push_byte(8'($urandom));
            write_csr(CSR_CHUNKED_MODE, BODY_LEN_W'(0));
            write_csr(CSR_LENGTH_KNOWN, BODY_LEN_W'(0));
            repeat (6) push_byte(8'($urandom));
            write_csr(CSR_LENGTH_KNOWN, BODY_LEN_W'(1));
            write_csr(CSR_BODY_LENGTH, '1);
         end
      endcase
      repeat (40) push_byte(8'($urandom));

      wait_idle();
      repeat (8) @(negedge clock);
      if (expected_results.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      $display("Checked %0d results: %0d bytes before any error, %0d payload, %0d chunks,",
               results_seen, body_items, payload_seen, chunk_count);
      $display("%0d register writes; stream closed by %s with error code %0d.",
               csr_writes, ending.name(), live_state.err);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/hbd_pkg.sv
hdl/hbd_core.sv
hdl/http_body_chunked_deframer.sv
sim/http_body_chunked_deframer_test.sv
